### hw/rtl/jfd_pkg.sv
// Shared constants and payload types for the MJPEG frame delineator.
`timescale 1ns / 1ps

package jfd_pkg;

   // Frame store geometry.
   localparam int STORE_BYTES = 262144;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CNT_W       = ADDR_W + 1;

   // Nesting counter.
   localparam int MAX_NEST = 15;
   localparam int NEST_W   = $clog2(MAX_NEST + 1);

   // Marker bytes.
   localparam logic [7:0] CODE_PREFIX = 8'hff;
   localparam logic [7:0] CODE_SOI    = 8'hd8;
   localparam logic [7:0] CODE_EOI    = 8'hd9;

   // Request codes.
   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_RESTART = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   // Result kinds.
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Frame status codes.
   localparam logic STATUS_DELIVERED = 1'b0;
   localparam logic STATUS_OVERSIZE  = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  data_byte;
      logic [17:0] read_addr;
   } jfd_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [18:0] frame_length;
      logic        frame_status;
      logic [7:0]  read_byte;
   } jfd_rsp_type;

endpackage

### hw/rtl/jpeg_frame_delineator_top.sv
// MJPEG frame delineator: marker parser, frame store and result pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  jfd_req_type (request, byte, address)
// rsp_      out        rsp_valid/rsp_stall  jfd_rsp_type (report or read byte)
// csr_      in         csr_wr_en            frame_limit (19 bits)
//
// One request is taken every cycle while req_stall is low. A result passes
// the stage-one register, which holds the registered frame store read, and
// then the output register. Reset is synchronous and clears the parser and
// the pipeline; the frame store is not cleared. When the output register is
// full and stalled, the input stalls only if a result also waits behind it.

module jpeg_frame_delineator_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  jfd_pkg::jfd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output jfd_pkg::jfd_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [18:0]          csr_wr_data
);
   import jfd_pkg::*;

   localparam logic [CNT_W-1:0]  STORE_COUNT = CNT_W'(STORE_BYTES);
   localparam logic [NEST_W-1:0] NEST_LIMIT  = NEST_W'(MAX_NEST);

   // Configuration.
   logic [18:0] limit_ff;

   // Parser state.
   logic              pending_ff, pending_in;
   logic [NEST_W-1:0] nest_ff, nest_in;
   logic              in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;

   // Frame store.
   logic [7:0]        store_mem [STORE_BYTES];
   logic [7:0]        store_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;

   // Pipeline.
   logic        s1_valid_ff, s1_valid_in;
   jfd_rsp_type s1_data_ff, s1_data_in;
   logic        s1_zero_ff;
   jfd_rsp_type s1_out;
   logic        rsp_valid_ff;
   jfd_rsp_type rsp_data_ff;

   logic             accept;
   logic             s1_advance;
   logic             s1_load;
   logic             is_byte, is_read;
   logic             outer_soi, do_put, fits, report;
   logic [CNT_W-1:0] lim_eff, base_count;
   logic             base_ovf;
   logic [CNT_W-1:0] put_count;
   logic             put_ovf;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || s1_advance;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;
   assign is_byte    = accept && (req_data.req_type == REQ_BYTE);
   assign is_read    = accept && (req_data.req_type == REQ_READ);

   assign lim_eff = (limit_ff > 19'(STORE_COUNT)) ? STORE_COUNT : CNT_W'(limit_ff);

   // The FF of an outer SOI always lands at offset 0, so it is never written:
   // a read of offset 0 returns FF directly. Only the D8 goes to the store.
   always_comb begin
      pending_in  = pending_ff;
      nest_in     = nest_ff;
      in_frame_in = in_frame_ff;
      outer_soi   = 1'b0;
      do_put      = 1'b0;
      report      = 1'b0;

      if (is_byte) begin
         if (!pending_ff) begin
            do_put     = in_frame_ff;
            pending_in = (req_data.data_byte == CODE_PREFIX);
         end else begin
            pending_in = 1'b0;
            if (req_data.data_byte == CODE_SOI) begin
               outer_soi = (nest_ff == '0);
               do_put    = 1'b1;
               if (outer_soi) begin
                  in_frame_in = 1'b1;
               end
               if (nest_ff < NEST_LIMIT) begin
                  nest_in = nest_ff + NEST_W'(1);
               end
            end else begin
               do_put = in_frame_ff;
               if (req_data.data_byte == CODE_EOI && in_frame_ff && nest_ff != '0) begin
                  nest_in = nest_ff - NEST_W'(1);
                  if (nest_ff == NEST_W'(1)) begin
                     report      = 1'b1;
                     in_frame_in = 1'b0;
                  end
               end
            end
         end
      end

      if (outer_soi) begin
         base_count = CNT_W'(1);
         base_ovf   = (lim_eff == '0);
      end else begin
         base_count = count_ff;
         base_ovf   = ovf_ff;
      end

      fits      = base_count < lim_eff;
      mem_we    = do_put && fits;
      mem_waddr = base_count[ADDR_W-1:0];
      count_in  = base_count;
      ovf_in    = base_ovf;
      if (do_put) begin
         ovf_in = base_ovf || !fits;
         if (base_count < STORE_COUNT) begin
            count_in = base_count + CNT_W'(1);
         end
      end
      // Length and status of a report are taken after the EOI byte is counted,
      // before the parser counters clear.
      put_count = count_in;
      put_ovf   = ovf_in;
      if (!is_byte) begin
         count_in = count_ff;
         ovf_in   = ovf_ff;
      end

      if (report || (accept && req_data.req_type == REQ_RESTART)) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
      if (accept && req_data.req_type == REQ_RESTART) begin
         pending_in  = 1'b0;
         nest_in     = '0;
         in_frame_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (s1_load) begin
         s1_valid_in = report || is_read;
         if (is_read) begin
            s1_data_in.result_kind  = KIND_READ;
            s1_data_in.frame_length = '0;
            s1_data_in.frame_status = STATUS_DELIVERED;
         end else begin
            s1_data_in.result_kind  = KIND_REPORT;
            s1_data_in.frame_length = 19'(put_count);
            s1_data_in.frame_status = put_ovf ? STATUS_OVERSIZE : STATUS_DELIVERED;
         end
         s1_data_in.read_byte = '0;
      end
   end

   always_comb begin
      s1_out = s1_data_ff;
      if (s1_data_ff.result_kind == KIND_READ) begin
         s1_out.read_byte = s1_zero_ff ? CODE_PREFIX : store_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= 19'(STORE_BYTES);
         pending_ff   <= 1'b0;
         nest_ff      <= '0;
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         pending_ff  <= pending_in;
         nest_ff     <= nest_in;
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      if (is_read) begin
         s1_zero_ff <= (req_data.read_addr[ADDR_W-1:0] == '0);
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff <= s1_out;
      end
   end

   // Single write port and single registered read port. A read request is
   // never in the same cycle as a byte write, and a write is visible to a
   // read accepted in any later cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= req_data.data_byte;
      end
      if (is_read) begin
         store_q_ff <= store_mem[req_data.read_addr[ADDR_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sim/tb_top.sv
// Testbench for the MJPEG frame delineator: marker streams checked against a behavioral parser.
`timescale 1ns / 1ps

module tb_top;
   import jfd_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         HOLD_CYCLES  = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   jfd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   jfd_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [18:0] csr_wr_data = '0;

   jpeg_frame_delineator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Behavioral copy of the parser state, the limit register and the frame store.
   logic [18:0]       sh_limit = 19'd262144;
   logic              sh_prefix_seen = 1'b0;
   logic [NEST_W-1:0] sh_depth = '0;
   logic              sh_in_frame = 1'b0;
   logic [CNT_W-1:0]  sh_count = '0;
   logic              sh_oversize = 1'b0;
   logic [7:0]        sh_mem [STORE_BYTES];
   // Frames always fill the store from offset 0, so entries below this are written.
   int                sh_fill = 0;

   jfd_rsp_type awaited_rsp[$];

   int mismatches = 0;
   int sent_items = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   function automatic void store_frame_byte(input logic [7:0] b);
      int eff;
      eff = (int'(sh_limit) > STORE_BYTES) ? STORE_BYTES : int'(sh_limit);
      if (int'(sh_count) < eff) begin
         sh_mem[sh_count] = b;
         if (int'(sh_count) >= sh_fill) sh_fill = int'(sh_count) + 1;
      end else begin
         sh_oversize = 1'b1;
      end
      if (int'(sh_count) < STORE_BYTES) sh_count = sh_count + 1'b1;
   endfunction

   // Advances the parser copy by one accepted transfer and queues any result it causes.
   function automatic void follow_stream(input jfd_req_type r);
      jfd_rsp_type res;
      logic [7:0]  b;
      res = '0;
      b = r.data_byte;
      case (r.req_type)
         REQ_RESTART: begin
            sh_prefix_seen = 1'b0;
            sh_depth = '0;
            sh_in_frame = 1'b0;
            sh_count = '0;
            sh_oversize = 1'b0;
         end
         REQ_READ: begin
            res.result_kind = KIND_READ;
            res.read_byte = sh_mem[r.read_addr];
            awaited_rsp.push_back(res);
         end
         REQ_BYTE: begin
            if (!sh_prefix_seen) begin
               if (sh_in_frame) store_frame_byte(b);
               if (b == CODE_PREFIX) sh_prefix_seen = 1'b1;
            end else begin
               // The byte after a prefix is always a marker code, even another prefix.
               sh_prefix_seen = 1'b0;
               if (b == CODE_SOI) begin
                  if (sh_depth == 0) begin
                     sh_in_frame = 1'b1;
                     sh_count = '0;
                     sh_oversize = 1'b0;
                     store_frame_byte(CODE_PREFIX);
                  end
                  store_frame_byte(b);
                  if (sh_depth < MAX_NEST) sh_depth = sh_depth + 1'b1;
               end else begin
                  if (sh_in_frame) store_frame_byte(b);
                  if (b == CODE_EOI && sh_in_frame && sh_depth != 0) begin
                     sh_depth = sh_depth - 1'b1;
                     if (sh_depth == 0) begin
                        res.result_kind = KIND_REPORT;
                        res.frame_length = sh_count;
                        res.frame_status = sh_oversize ? STATUS_OVERSIZE : STATUS_DELIVERED;
                        awaited_rsp.push_back(res);
                        sh_in_frame = 1'b0;
                        sh_count = '0;
                        sh_oversize = 1'b0;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      jfd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = awaited_rsp.pop_front();
            compare_field("result_kind", want.result_kind, rsp_data.result_kind);
            compare_field("frame_length", want.frame_length, rsp_data.frame_length);
            compare_field("frame_status", want.frame_status, rsp_data.frame_status);
            compare_field("read_byte", want.read_byte, rsp_data.read_byte);
         end
      end
   end

   // Receiver side: random stalls, or a long hold-off counted here when one is asked for.
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_req(input jfd_req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      follow_stream(r);
      if (r.req_type != REQ_UNUSED) sent_items++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      jfd_req_type r;
      r.req_type = REQ_BYTE;
      r.data_byte = b;
      r.read_addr = 18'($urandom);
      send_req(r);
   endtask

   task automatic send_read(input int addr);
      jfd_req_type r;
      r.req_type = REQ_READ;
      r.data_byte = 8'($urandom);
      r.read_addr = addr[ADDR_W-1:0];
      send_req(r);
   endtask

   task automatic send_read_any();
      if (sh_fill > 0) send_read($urandom_range(sh_fill - 1));
   endtask

   task automatic send_ctl(input logic [1:0] kind);
      jfd_req_type r;
      r.req_type = kind;
      r.data_byte = 8'($urandom);
      r.read_addr = 18'($urandom);
      send_req(r);
   endtask

   task automatic send_marker(input logic [7:0] code);
      send_byte(CODE_PREFIX);
      send_byte(code);
   endtask

   // One well-formed frame with random content and random nested thumbnails.
   task automatic send_frame(input int body_len, input int depth_cap);
      int         depth;
      int         roll;
      logic [7:0] b;
      send_marker(CODE_SOI);
      depth = 1;
      for (int i = 0; i < body_len; i++) begin
         roll = $urandom_range(99);
         if (roll < 6 && depth < depth_cap) begin
            send_marker(CODE_SOI);
            depth++;
         end else if (roll < 12 && depth > 1) begin
            send_marker(CODE_EOI);
            depth--;
         end else if (roll < 18) begin
            do b = 8'($urandom); while (b == CODE_SOI || b == CODE_EOI);
            send_marker(b);
         end else begin
            do b = 8'($urandom); while (b == CODE_PREFIX);
            send_byte(b);
         end
      end
      repeat (depth) send_marker(CODE_EOI);
   endtask

   // Lets every expected result drain, then idles further so that items that give none also pass through.
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [18:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sh_limit = value;
   endtask

   task automatic test_markers();
      send_idle_pct = 0;
      stall_pct = 0;
      send_marker(CODE_EOI);
      send_marker(CODE_SOI);
      send_byte(8'h00);
      send_marker(CODE_PREFIX);
      send_byte(8'h7f);
      send_marker(CODE_EOI);
      send_read(0);
      send_read(7);
      send_ctl(REQ_UNUSED);
      // A restart inside a frame drops it, so the end marker after it is stray.
      send_marker(CODE_SOI);
      send_byte(8'hab);
      send_ctl(REQ_RESTART);
      send_marker(CODE_EOI);
      send_read(2);
      finish_phase();
      set_limit(19'd0);
      send_marker(CODE_SOI);
      send_marker(CODE_EOI);
      send_read(3);
      finish_phase();
   endtask

   task automatic test_frame_limits();
      logic [18:0] limits[8];
      limits = '{19'd1, 19'd2, 19'd0, 19'd7, 19'h7ffff, 19'd24, 19'd40, 19'd262144};
      send_idle_pct = 14;
      stall_pct = 14;
      foreach (limits[i]) begin
         finish_phase();
         set_limit(limits[i]);
         repeat (4) begin
            send_frame($urandom_range(0, 12), $urandom_range(1, 3));
            send_read_any();
         end
      end
      finish_phase();
   endtask

   task automatic test_deep_nesting();
      int k;
      send_idle_pct = 14;
      stall_pct = 14;
      repeat (4) begin
         k = $urandom_range(13, 18);
         repeat (k) begin
            send_marker(CODE_SOI);
            send_byte(8'($urandom_range(0, 254)));
         end
         repeat (k) send_marker(CODE_EOI);
         send_read_any();
      end
      finish_phase();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (40) send_read_any();
      send_frame(10, 2);
      repeat (10) send_read_any();
      finish_phase();
   endtask

   task automatic test_random_stream(input int n_items, input int idle, input int stall,
                                     input logic [18:0] limit);
      int stop_at;
      int roll;
      finish_phase();
      set_limit(limit);
      send_idle_pct = idle;
      stall_pct = stall;
      stop_at = sent_items + n_items;
      while (sent_items < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 62) begin
            send_frame($urandom_range(0, 30),
                       ($urandom_range(9) == 0) ? 18 : $urandom_range(1, 3));
         end else if (roll < 72) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else if (roll < 84) begin
            repeat ($urandom_range(1, 3)) send_read_any();
         end else if (roll < 90) begin
            send_marker(CODE_SOI);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 254)));
            send_ctl(REQ_RESTART);
         end else if (roll < 95) begin
            if ($urandom_range(1)) send_ctl(REQ_RESTART);
            else send_marker(CODE_EOI);
         end else begin
            send_ctl(REQ_UNUSED);
         end
      end
      finish_phase();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_markers();
      test_frame_limits();
      test_deep_nesting();
      test_backpressure();
      test_random_stream(210, 0, 0, 19'd262144);
      test_random_stream(210, 68, 0, 19'd40);
      test_random_stream(210, 0, 68, 19'h7ffff);
      test_random_stream(210, 14, 14, 19'($urandom_range(1, 60)));
      finish_phase();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("%0t: timeout, %0d results still awaited", $time, awaited_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/jfd_pkg.sv
hw/rtl/jpeg_frame_delineator_top.sv
sim/tb_top.sv
